// File: src/pointer_event_queue_assert.svh
// ============================================================================
// Pointer event queue assertion macros
// Concurrent assertion helpers for the pointer event queue. In synthesis the
// macros expand to nothing.
// ============================================================================
`ifndef POINTER_EVENT_QUEUE_ASSERT_SVH
`define POINTER_EVENT_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define PEQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pointer_event_queue: assertion failed");

// Next-cycle implication, checked outside reset.
`define PEQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pointer_event_queue: assertion failed");

`else

`define PEQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PEQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: src/peq_pkg.sv
// ============================================================================
// Pointer event queue package
// Request codes, register indexes, reset values and the click ring entry type.
// ============================================================================
`default_nettype none

package peq_pkg;

  // Field widths
  localparam int REQ_W    = 2;
  localparam int POS_W    = 16;
  localparam int BTN_W    = 5;
  localparam int MSEC_W   = 32;
  localparam int COUNT_W  = 32;
  localparam int CFG_IDX_W = 2;

  // Default click ring depth
  localparam int DEFAULT_RING_DEPTH = 16;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_TRACK = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_WARP  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_MIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_MIN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_MAX_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_MAX_Y = 2'd3;

  // Screen rectangle reset values
  localparam logic signed [POS_W-1:0] SCREEN_MIN_X_RST = 16'sd0;
  localparam logic signed [POS_W-1:0] SCREEN_MIN_Y_RST = 16'sd0;
  localparam logic signed [POS_W-1:0] SCREEN_MAX_X_RST = 16'sd640;
  localparam logic signed [POS_W-1:0] SCREEN_MAX_Y_RST = 16'sd480;

  // One click ring snapshot
  typedef struct packed {
    logic [POS_W-1:0]   y;
    logic [POS_W-1:0]   x;
    logic [BTN_W-1:0]   buttons;
    logic [COUNT_W-1:0] count;
    logic [MSEC_W-1:0]  msec;
  } ring_entry_t;

endpackage

`default_nettype wire

// File: src/pointer_event_queue.sv
// ============================================================================
// Pointer event queue
// Keeps the current pointer state and a ring of click snapshots. Track and
// warp transactions update the state; read transactions return the oldest
// snapshot, the current state, or an all-zero result if nothing changed.
// ============================================================================
//
//  Channel   Handshake                 Payload
//  -------   -----------------------   ----------------------------------------
//  input     start / busy              in_req_type, in_pos_x, in_pos_y,
//                                      in_button_bits, in_event_msec
//  result    out_strobe (one cycle)    out_fresh, out_from_ring, out_x, out_y,
//                                      out_buttons, out_msec
//  config    cfg_valid / cfg_ready     cfg_index, cfg_wdata
//
//  One transaction is accepted every cycle; busy stays low.
//  A read result appears on out_strobe after passing through the input register,
//  then through the update logic into the result register.
//  The ring head is prefetched from the ring memory's registered read port,
//  which keeps each item to a single pass.
//  Synchronous reset clears all control state; ring contents are not cleared.
//  The receiver cannot stall, so no result is ever held back.
`default_nettype none

`include "pointer_event_queue_assert.svh"

module pointer_event_queue
  import peq_pkg::*;
#(
  parameter int RING_DEPTH = DEFAULT_RING_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Input channel
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [REQ_W-1:0]            in_req_type,
  input  wire logic signed [POS_W-1:0]     in_pos_x,
  input  wire logic signed [POS_W-1:0]     in_pos_y,
  input  wire logic [BTN_W-1:0]            in_button_bits,
  input  wire logic [MSEC_W-1:0]           in_event_msec,
  // Result channel
  output logic                             out_strobe,
  output logic                             out_fresh,
  output logic                             out_from_ring,
  output logic signed [POS_W-1:0]          out_x,
  output logic signed [POS_W-1:0]          out_y,
  output logic [BTN_W-1:0]                 out_buttons,
  output logic [MSEC_W-1:0]                out_msec,
  // Configuration channel
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic signed [POS_W-1:0]     cfg_wdata
);

  localparam int IDX_W = $clog2(RING_DEPTH);

  // Wrap an index at the ring depth.
  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  // Handshake
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  logic accept;
  assign accept = start && !busy;

  // Configuration registers
  logic signed [POS_W-1:0] min_x_r, min_y_r, max_x_r, max_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r <= SCREEN_MIN_X_RST;
      min_y_r <= SCREEN_MIN_Y_RST;
      max_x_r <= SCREEN_MAX_X_RST;
      max_y_r <= SCREEN_MAX_Y_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SCREEN_MIN_X: min_x_r <= cfg_wdata;
        CFG_SCREEN_MIN_Y: min_y_r <= cfg_wdata;
        CFG_SCREEN_MAX_X: max_x_r <= cfg_wdata;
        CFG_SCREEN_MAX_Y: max_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  logic                    in_vld_r;
  logic [REQ_W-1:0]        req_r;
  logic signed [POS_W-1:0] px_r, py_r;
  logic [BTN_W-1:0]        pb_r;
  logic [MSEC_W-1:0]       ms_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req_type;
      px_r  <= in_pos_x;
      py_r  <= in_pos_y;
      pb_r  <= in_button_bits;
      ms_r  <= in_event_msec;
    end
  end

  // Pointer state and ring control
  logic signed [POS_W-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [BTN_W-1:0]        cur_btn_r, cur_btn_nxt;
  logic [MSEC_W-1:0]       cur_ms_r, cur_ms_nxt;
  logic [COUNT_W-1:0]      upd_cnt_r, upd_cnt_nxt;
  logic [COUNT_W-1:0]      last_cnt_r, last_cnt_nxt;
  logic [IDX_W-1:0]        rd_idx_r, rd_idx_nxt, wr_idx_r, wr_idx_nxt;
  logic                    full_r, full_nxt;

  // Ring memory write side and prefetched head
  logic                    ring_we;
  ring_entry_t             ring_wdata;
  ring_entry_t             head_r;

  // Result register next values
  logic                    strobe_nxt, fresh_nxt, from_ring_nxt;
  logic signed [POS_W-1:0] ox_nxt, oy_nxt;
  logic [BTN_W-1:0]        ob_nxt;
  logic [MSEC_W-1:0]       om_nxt;

  logic                    warp_inside;
  logic [COUNT_W-1:0]      rep_cnt;

  assign warp_inside = (px_r >= min_x_r) && (px_r < max_x_r) &&
                       (py_r >= min_y_r) && (py_r < max_y_r);

  // Update logic for one transaction
  always_comb begin
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    cur_btn_nxt   = cur_btn_r;
    cur_ms_nxt    = cur_ms_r;
    upd_cnt_nxt   = upd_cnt_r;
    last_cnt_nxt  = last_cnt_r;
    rd_idx_nxt    = rd_idx_r;
    wr_idx_nxt    = wr_idx_r;
    full_nxt      = full_r;
    ring_we       = 1'b0;
    ring_wdata    = '{y: py_r, x: px_r, buttons: pb_r,
                      count: upd_cnt_r + 1'b1, msec: ms_r};
    strobe_nxt    = 1'b0;
    fresh_nxt     = 1'b0;
    from_ring_nxt = 1'b0;
    ox_nxt        = '0;
    oy_nxt        = '0;
    ob_nxt        = '0;
    om_nxt        = '0;
    rep_cnt       = upd_cnt_r;

    if (in_vld_r) begin
      case (req_r)
        REQ_TRACK: begin
          cur_x_nxt   = px_r;
          cur_y_nxt   = py_r;
          cur_btn_nxt = pb_r;
          cur_ms_nxt  = ms_r;
          upd_cnt_nxt = upd_cnt_r + 1'b1;
          // A button change pushes a snapshot unless the ring is marked full.
          if (!full_r && (pb_r != cur_btn_r)) begin
            ring_we    = 1'b1;
            wr_idx_nxt = next_slot(wr_idx_r);
            if (next_slot(wr_idx_r) == rd_idx_r) begin
              full_nxt = 1'b1;
            end
          end
        end
        REQ_WARP: begin
          // Buttons are kept, so a warp never pushes.
          if (warp_inside) begin
            cur_x_nxt   = px_r;
            cur_y_nxt   = py_r;
            cur_ms_nxt  = ms_r;
            upd_cnt_nxt = upd_cnt_r + 1'b1;
          end
        end
        REQ_READ: begin
          strobe_nxt = 1'b1;
          // Nothing changed since the last read: report an all-zero result.
          if (last_cnt_r != upd_cnt_r) begin
            fresh_nxt = 1'b1;
            full_nxt  = 1'b0;
            if (rd_idx_r != wr_idx_r) begin
              from_ring_nxt = 1'b1;
              ox_nxt        = head_r.x;
              oy_nxt        = head_r.y;
              ob_nxt        = head_r.buttons;
              om_nxt        = head_r.msec;
              rep_cnt       = head_r.count;
              rd_idx_nxt    = next_slot(rd_idx_r);
            end else begin
              ox_nxt  = cur_x_r;
              oy_nxt  = cur_y_r;
              ob_nxt  = cur_btn_r;
              om_nxt  = cur_ms_r;
              rep_cnt = upd_cnt_r;
            end
            last_cnt_nxt = rep_cnt;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r    <= '0;
      cur_y_r    <= '0;
      cur_btn_r  <= '0;
      cur_ms_r   <= '0;
      upd_cnt_r  <= '0;
      last_cnt_r <= '0;
      rd_idx_r   <= '0;
      wr_idx_r   <= '0;
      full_r     <= 1'b0;
    end else begin
      cur_x_r    <= cur_x_nxt;
      cur_y_r    <= cur_y_nxt;
      cur_btn_r  <= cur_btn_nxt;
      cur_ms_r   <= cur_ms_nxt;
      upd_cnt_r  <= upd_cnt_nxt;
      last_cnt_r <= last_cnt_nxt;
      rd_idx_r   <= rd_idx_nxt;
      wr_idx_r   <= wr_idx_nxt;
      full_r     <= full_nxt;
    end
  end

  // Click ring memory. The read port follows the next read index, so the
  // head entry is ready when the next read arrives; a write to that slot
  // in the same cycle is forwarded.
  ring_entry_t ring_mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[wr_idx_r] <= ring_wdata;
    end
    if (ring_we && (wr_idx_r == rd_idx_nxt)) begin
      head_r <= ring_wdata;
    end else begin
      head_r <= ring_mem[rd_idx_nxt];
    end
  end

  // Result register
  logic                    strobe_r, fresh_r, from_ring_r;
  logic signed [POS_W-1:0] ox_r, oy_r;
  logic [BTN_W-1:0]        ob_r;
  logic [MSEC_W-1:0]       om_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fresh_r     <= fresh_nxt;
    from_ring_r <= from_ring_nxt;
    ox_r        <= ox_nxt;
    oy_r        <= oy_nxt;
    ob_r        <= ob_nxt;
    om_r        <= om_nxt;
  end

  assign out_strobe    = strobe_r;
  assign out_fresh     = fresh_r;
  assign out_from_ring = from_ring_r;
  assign out_x         = ox_r;
  assign out_y         = oy_r;
  assign out_buttons   = ob_r;
  assign out_msec      = om_r;

  // Assertions
  `PEQ_ASSERT_NXT(a_read_gives_result, clk, rst_n, in_vld_r && (req_r == REQ_READ), out_strobe)
  `PEQ_ASSERT_IMP(a_full_means_met, clk, rst_n, full_r, rd_idx_r == wr_idx_r)
  `PEQ_ASSERT_IMP(a_ring_implies_fresh, clk, rst_n, out_strobe && out_from_ring, out_fresh)
  `PEQ_ASSERT_IMP(a_stale_is_zero, clk, rst_n, out_strobe && !out_fresh, (out_msec == '0) && (out_buttons == '0) && (out_x == '0) && (out_y == '0))

endmodule

`default_nettype wire
